/* rtl/core/serial_line_capture_assert.svh */
// ----------------------------------------------------------------------------
// Serial line capture assertion macros
// Shared concurrent assertion forms for the capture logic.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_CAPTURE_ASSERT_SVH
`define SERIAL_LINE_CAPTURE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("serial line capture: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("serial line capture: next-cycle check failed");

`endif

/* rtl/core/scl_pkg.sv */
// ----------------------------------------------------------------------------
// Serial line capture package
// Types, codes and character constants shared by the capture modules.
// ----------------------------------------------------------------------------
package scl_pkg;

   localparam int MAX_LEN_DEFAULT = 128;
   localparam int BYTE_W          = 8;
   localparam int CSR_IDX_W       = 1;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_ARM  = 2'd1,
      KIND_READ = 2'd2
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_LISTEN_MODEM  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENTENCE_TYPE = 1'd1;

   localparam logic [BYTE_W-1:0] CHAR_CTRL_MAX  = 8'd31;
   localparam logic [BYTE_W-1:0] CHAR_PRINT_MIN = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_PROMPT    = 8'd62;
   localparam logic [BYTE_W-1:0] CHAR_CR        = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR    = 8'd36;
   localparam logic [BYTE_W-1:0] CHAR_NUL       = 8'd0;
   localparam int                TYPE_POS       = 5;

   typedef struct packed {
      logic [1:0]        kind;
      logic [BYTE_W-1:0] rx_byte;
      logic [BYTE_W-1:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic              listen_modem;
      logic [BYTE_W-1:0] sentence_type_char;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } buf_wr_type;

   typedef struct packed {
      logic              line_done;
      logic [BYTE_W-1:0] line_length;
      logic              switch_to_pc;
   } status_type;

endpackage

/* rtl/core/scl_if.sv */
// ----------------------------------------------------------------------------
// Serial line capture channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface scl_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                kind;
   logic [scl_pkg::BYTE_W-1:0] rx_byte;
   logic [scl_pkg::BYTE_W-1:0] read_index;

   modport source (output valid, output kind, output rx_byte, output read_index,
                   input ready);
   modport sink   (input valid, input kind, input rx_byte, input read_index,
                   output ready);
endinterface

interface scl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [scl_pkg::BYTE_W-1:0] read_byte;
   logic                      line_done;
   logic [scl_pkg::BYTE_W-1:0] line_length;
   logic                      switch_to_pc;

   modport source (output valid, output read_byte, output line_done,
                   output line_length, output switch_to_pc, input ready);
   modport sink   (input valid, input read_byte, input line_done,
                   input line_length, input switch_to_pc, output ready);
endinterface

/* rtl/core/scl_ram.sv */
// ----------------------------------------------------------------------------
// Serial line capture RAM
// Generic single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module scl_ram #(
   parameter int WIDTH = scl_pkg::BYTE_W,
   parameter int DEPTH = scl_pkg::MAX_LEN_DEFAULT + 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/scl_ctrl.sv */
// ----------------------------------------------------------------------------
// Serial line capture control
// Fill position and stop flag, line rules for modem and GPS mode.
// ----------------------------------------------------------------------------
`include "serial_line_capture_assert.svh"

module scl_ctrl #(
   parameter int MAX_LEN = scl_pkg::MAX_LEN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  scl_pkg::req_item_type item,
   input  scl_pkg::cfg_type      cfg,
   output scl_pkg::buf_wr_type   buf_wr,
   output scl_pkg::status_type   status
);

   localparam int FW = $clog2(MAX_LEN + 1);

   logic [FW-1:0]              fill_ff;
   logic [FW-1:0]              fill_in;
   logic                       stopped_ff;
   logic                       stopped_in;
   logic                       pulse;
   logic                       wr_en;
   logic [scl_pkg::BYTE_W-1:0] wr_data;
   logic [scl_pkg::BYTE_W-1:0] b;
   logic                       fill_nz;
   logic                       full;
   logic                       modem_end;
   logic                       gps_end;
   logic                       type_miss;

   assign b         = item.rx_byte;
   assign fill_nz   = (fill_ff != '0);
   assign full      = (fill_ff >= FW'(MAX_LEN));
   assign modem_end = ((b <= scl_pkg::CHAR_CTRL_MAX) && fill_nz) ||
                      (b == scl_pkg::CHAR_PROMPT) || full;
   assign gps_end   = ((b == scl_pkg::CHAR_CR) && fill_nz) || full;
   assign type_miss = (fill_ff == FW'(scl_pkg::TYPE_POS)) &&
                      (b != cfg.sentence_type_char);

   always_comb begin
      fill_in    = fill_ff;
      stopped_in = stopped_ff;
      pulse      = 1'b0;
      wr_en      = 1'b0;
      wr_data    = scl_pkg::CHAR_NUL;
      if (fire) begin
         unique case (item.kind)
            scl_pkg::KIND_BYTE: begin
               if (!stopped_ff) begin
                  if (cfg.listen_modem) begin
                     if (modem_end) begin
                        wr_en      = 1'b1;
                        stopped_in = 1'b1;
                     end else if (b >= scl_pkg::CHAR_PRINT_MIN) begin
                        wr_en   = 1'b1;
                        wr_data = b;
                        fill_in = fill_ff + FW'(1);
                     end
                  end else begin
                     if (gps_end) begin
                        wr_en      = 1'b1;
                        stopped_in = 1'b1;
                        pulse      = 1'b1;
                     end else if ((b == scl_pkg::CHAR_DOLLAR) || fill_nz) begin
                        if (type_miss) begin
                           fill_in = '0;
                        end else begin
                           wr_en   = 1'b1;
                           wr_data = b;
                           fill_in = fill_ff + FW'(1);
                        end
                     end
                  end
               end
            end
            scl_pkg::KIND_ARM: begin
               fill_in    = '0;
               stopped_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         stopped_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         stopped_ff <= stopped_in;
      end
   end

   assign buf_wr.en           = wr_en;
   assign buf_wr.addr         = scl_pkg::BYTE_W'(fill_ff);
   assign buf_wr.data         = wr_data;
   assign status.line_done    = stopped_in;
   assign status.line_length  = scl_pkg::BYTE_W'(fill_in);
   assign status.switch_to_pc = pulse;

   `SCL_ASSERT_NEXT(a_stopped_holds, clock, reset,
      fire && (item.kind == scl_pkg::KIND_BYTE) && stopped_ff,
      stopped_ff && $stable(fill_ff))
   `SCL_ASSERT_NEXT(a_store_advances, clock, reset,
      wr_en && !stopped_in, fill_ff == $past(fill_ff) + FW'(1))
   `SCL_ASSERT_SAME(a_pulse_gps_end, clock, reset,
      pulse, !cfg.listen_modem && wr_en && (wr_data == scl_pkg::CHAR_NUL))

endmodule

/* rtl/core/serial_line_capture.sv */
// ----------------------------------------------------------------------------
// Serial line capture
// Captures one text line from received bytes into a buffer and reads it back.
// ----------------------------------------------------------------------------
// The block takes one request item per clock while the result channel is not
// stalled, and returns one result item for each: the request is held in an
// input register, the line rules and the buffer write or read run as it moves
// to the output register, where the result sits until taken. The line buffer
// is a RAM of MAX_LEN + 1 bytes with a registered read port, so a read item
// sees every byte written by earlier items. The buffer is not cleared after
// reset; read only positions that the current or an earlier line has written.
module serial_line_capture #(
   parameter int MAX_LEN = scl_pkg::MAX_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   scl_req_if.sink                       req_ch,
   scl_rsp_if.source                     rsp_ch,
   input  logic                          csr_wen,
   input  logic [scl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [scl_pkg::BYTE_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_LEN + 1);

   logic                       s1_valid_ff;
   scl_pkg::req_item_type      s1_item_ff;
   logic                       s1_adv;
   logic                       s2_valid_ff;
   logic                       s2_valid_in;
   scl_pkg::status_type        s2_status_ff;
   logic                       s2_hit_ff;
   scl_pkg::cfg_type           cfg_ff;
   scl_pkg::cfg_type           cfg_in;
   scl_pkg::buf_wr_type        buf_wr;
   scl_pkg::status_type        status;
   scl_pkg::req_item_type      req_item;
   logic                       rd_en;
   logic [scl_pkg::BYTE_W-1:0] rd_data;

   assign s1_adv       = s1_valid_ff && (!s2_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign s2_valid_in  = s1_adv || (s2_valid_ff && !rsp_ch.ready);

   assign req_item.kind       = req_ch.kind;
   assign req_item.rx_byte    = req_ch.rx_byte;
   assign req_item.read_index = req_ch.read_index;

   assign rd_en = s1_adv && (s1_item_ff.kind == scl_pkg::KIND_READ) &&
                  (s1_item_ff.read_index <= scl_pkg::BYTE_W'(MAX_LEN));

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            scl_pkg::CSR_LISTEN_MODEM:  cfg_in.listen_modem       = csr_wdata[0];
            scl_pkg::CSR_SENTENCE_TYPE: cfg_in.sentence_type_char = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         cfg_ff      <= '0;
      end else begin
         s1_valid_ff <= !req_ch.ready || req_ch.valid;
         s2_valid_ff <= s2_valid_in;
         cfg_ff      <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_item_ff <= req_item;
      end
      if (s1_adv) begin
         s2_status_ff <= status;
         s2_hit_ff    <= rd_en;
      end
   end

   scl_ctrl #(
      .MAX_LEN (MAX_LEN)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_adv),
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .buf_wr (buf_wr),
      .status (status)
   );

   scl_ram #(
      .WIDTH (scl_pkg::BYTE_W),
      .DEPTH (MAX_LEN + 1)
   ) u_line_buffer (
      .clock   (clock),
      .wr_en   (buf_wr.en),
      .wr_addr (buf_wr.addr[AW-1:0]),
      .wr_data (buf_wr.data),
      .rd_en   (rd_en),
      .rd_addr (s1_item_ff.read_index[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_ch.valid        = s2_valid_ff;
   assign rsp_ch.read_byte    = s2_hit_ff ? rd_data : '0;
   assign rsp_ch.line_done    = s2_status_ff.line_done;
   assign rsp_ch.line_length  = s2_status_ff.line_length;
   assign rsp_ch.switch_to_pc = s2_status_ff.switch_to_pc;

endmodule
